### hw/rtl/rsxu_pkg.sv
// Shared codes and types for the RISC subset execute unit.
`default_nettype none

package rsxu_pkg;

   localparam logic [3:0] ACT_ADD     = 4'd0;
   localparam logic [3:0] ACT_ADDI    = 4'd1;
   localparam logic [3:0] ACT_SUB     = 4'd2;
   localparam logic [3:0] ACT_SUBI    = 4'd3;
   localparam logic [3:0] ACT_SLT     = 4'd4;
   localparam logic [3:0] ACT_LI      = 4'd5;
   localparam logic [3:0] ACT_LA      = 4'd6;
   localparam logic [3:0] ACT_LW      = 4'd7;
   localparam logic [3:0] ACT_SW      = 4'd8;
   localparam logic [3:0] ACT_BEQ     = 4'd9;
   localparam logic [3:0] ACT_BNE     = 4'd10;
   localparam logic [3:0] ACT_J       = 4'd11;
   localparam logic [3:0] ACT_SYSCALL = 4'd12;
   localparam logic [3:0] ACT_LABEL   = 4'd13;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_HALT    = 2'd1;
   localparam logic [1:0] ST_BAD_SYS = 2'd2;
   localparam logic [1:0] ST_ADDR    = 2'd3;

   localparam logic [4:0]  REG_ZERO = 5'd0;
   localparam logic [4:0]  REG_SYS  = 5'd2;
   localparam logic [31:0] SYS_EXIT = 32'd10;

   // register file write (commit) port
   typedef struct packed {
      logic        en;
      logic [4:0]  addr;
      logic [31:0] data;
   } rf_wr_type;

endpackage

`default_nettype wire

### hw/rtl/rsxu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rsxu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and write of the same entry in one cycle returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/rsxu_regfile.sv
// Register file: two read ports on mirrored RAMs, valid bits and commit bypass.
`default_nettype none

module rsxu_regfile
   import rsxu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rd_en,
   input  wire logic [4:0]  rd_addr_a,
   input  wire logic [4:0]  rd_addr_b,
   input  wire rf_wr_type   wr,
   output logic      [4:0]  q_addr_a,
   output logic      [4:0]  q_addr_b,
   output logic      [31:0] q_data_a,
   output logic      [31:0] q_data_b
);

   logic [31:0] valid_ff, valid_in;
   rf_wr_type   cw_ff;
   logic [4:0]  addr_a_ff, addr_b_ff;
   logic [31:0] ram_a_q, ram_b_q;

   rsxu_ram #(.WIDTH(32), .DEPTH(32)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_a),
      .rd_data (ram_a_q)
   );

   rsxu_ram #(.WIDTH(32), .DEPTH(32)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_b),
      .rd_data (ram_b_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cw_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         if (wr.en) begin
            cw_ff <= wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         addr_a_ff <= rd_addr_a;
         addr_b_ff <= rd_addr_b;
      end
   end

   // the latest commit may have landed in the same cycle as the read
   always_comb begin
      q_data_a = '0;
      if (addr_a_ff != REG_ZERO) begin
         if (cw_ff.en && cw_ff.addr == addr_a_ff) begin
            q_data_a = cw_ff.data;
         end else if (valid_ff[addr_a_ff]) begin
            q_data_a = ram_a_q;
         end
      end
      q_data_b = '0;
      if (addr_b_ff != REG_ZERO) begin
         if (cw_ff.en && cw_ff.addr == addr_b_ff) begin
            q_data_b = cw_ff.data;
         end else if (valid_ff[addr_b_ff]) begin
            q_data_b = ram_b_q;
         end
      end
   end

   assign q_addr_a = addr_a_ff;
   assign q_addr_b = addr_b_ff;

endmodule

`default_nettype wire

### hw/rtl/rsxu_dmem.sv
// Data memory: byte address check, word RAM and the clearing sweep after reset.
`default_nettype none

module rsxu_dmem #(
   parameter int MEM_WORDS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] addr,
   input  wire logic        rd_en,
   input  wire logic        wr_en,
   input  wire logic [31:0] wr_data,
   output logic             addr_ok,
   output logic             busy,
   output logic      [31:0] rd_data
);

   localparam int          AW    = $clog2(MEM_WORDS);
   localparam logic [29:0] LIMIT = 30'(MEM_WORDS);
   localparam logic [AW-1:0] LAST = AW'(MEM_WORDS - 1);

   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;
   logic          neg_ok, pos_ok;
   logic [AW-1:0] idx;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [31:0]   ram_wdata;

   // signed address / 4 toward zero: -3..-1 still lands on word 0
   assign neg_ok  = (addr[31:2] == '1) && (addr[1:0] != 2'b00);
   assign pos_ok  = !addr[31] && (addr[31:2] < LIMIT);
   assign addr_ok = neg_ok || pos_ok;
   assign idx     = addr[31] ? '0 : addr[AW+1:2];

   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == LAST) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   assign ram_we    = clearing_ff || wr_en;
   assign ram_waddr = clearing_ff ? clr_idx_ff : idx;
   assign ram_wdata = clearing_ff ? '0 : wr_data;
   assign busy      = clearing_ff;

   rsxu_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (rd_en),
      .rd_addr (idx),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

### hw/rtl/risc_subset_execute_unit.sv
// Execute unit for a small integer instruction subset: top level.
//
// Each req item is one pre-decoded instruction; each produces exactly one rsp
// item with the next program line, the register write it made and a status.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// Pipeline: register file read -> execute, where the line counter,
// the halt flag and stores update -> writeback, where the register file is
// written and load data arrives -> rsp output register. One item is taken
// per cycle while req_stall is low, and passes each stage register in turn.
// Results of earlier items are forwarded into execute, so dependent
// instructions issue back to back with no bubbles.
// After reset the data memory is swept to zero, one word per cycle, which
// holds req_stall high until the sweep ends; the register file, line counter
// and halt flag clear at once. A stalled rsp holds its item; the pipeline
// behind it keeps filling and raises req_stall only when every stage is full.
// After an exit syscall every further item returns status halt, unchanged line.
`default_nettype none

module risc_subset_execute_unit
   import rsxu_pkg::*;
#(
   parameter int MEM_WORDS = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic        [3:0]  req_action,
   input  wire logic        [4:0]  req_dest_reg,
   input  wire logic        [4:0]  req_src_a_reg,
   input  wire logic        [4:0]  req_src_b_reg,
   input  wire logic signed [31:0] req_immediate,
   input  wire logic        [15:0] req_target_line,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic             [15:0] rsp_next_line,
   output logic                    rsp_write_enable,
   output logic             [4:0]  rsp_write_reg,
   output logic signed      [31:0] rsp_write_value,
   output logic             [1:0]  rsp_status
);

   // handshake and stage advance
   logic accept, rsp_free, s2_adv, s2_free, s1_adv, s1_free;

   // execute stage
   logic        s1_v_ff, s1_v_in;
   logic [3:0]  s1_action_ff;
   logic [4:0]  s1_dest_ff;
   logic [31:0] s1_imm_ff;
   logic [15:0] s1_target_ff;

   // writeback stage
   logic        s2_v_ff, s2_v_in;
   logic        s2_we_ff, s2_load_ff;
   logic [4:0]  s2_reg_ff;
   logic [31:0] s2_val_ff;
   logic [15:0] s2_next_ff;
   logic [1:0]  s2_status_ff;
   logic [31:0] s2_data;

   // architectural control state
   logic [15:0] pc_ff, pc_in;
   logic        halted_ff, halted_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_next_ff;
   logic        rsp_we_ff;
   logic [4:0]  rsp_reg_ff;
   logic [31:0] rsp_val_ff;
   logic [1:0]  rsp_status_ff;

   // register file and memory
   logic [4:0]  rd_addr_a, rd_addr_b, q_addr_a, q_addr_b;
   logic [31:0] q_data_a, q_data_b;
   rf_wr_type   rf_wr;
   logic        dm_ok, dm_busy, dm_rd_en, dm_wr_en;
   logic [31:0] dm_rdata;

   // execute results
   logic [31:0] op_a, op_b, sum;
   logic [15:0] next_line;
   logic        we, load, store, halt_set;
   logic [31:0] val;
   logic [1:0]  status;
   logic        we_fin;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_adv    = s2_v_ff && rsp_free;
   assign s2_free   = !s2_v_ff || rsp_free;
   assign s1_adv    = s1_v_ff && s2_free;
   assign s1_free   = !s1_v_ff || s2_free;
   assign req_stall = dm_busy || !s1_free;
   assign accept    = req_valid && !req_stall;

   // syscall reads r2 on port A; a store reads its data register on port B
   assign rd_addr_a = (req_action == ACT_SYSCALL) ? REG_SYS : req_src_a_reg;
   assign rd_addr_b = (req_action == ACT_SW) ? req_dest_reg : req_src_b_reg;

   rsxu_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr        (rf_wr),
      .q_addr_a  (q_addr_a),
      .q_addr_b  (q_addr_b),
      .q_data_a  (q_data_a),
      .q_data_b  (q_data_b)
   );

   // forward the item in writeback (its load data included)
   assign s2_data = s2_load_ff ? dm_rdata : s2_val_ff;
   assign op_a = (s2_v_ff && s2_we_ff && s2_reg_ff == q_addr_a) ? s2_data : q_data_a;
   assign op_b = (s2_v_ff && s2_we_ff && s2_reg_ff == q_addr_b) ? s2_data : q_data_b;
   assign sum  = op_a + s1_imm_ff;

   always_comb begin
      next_line = pc_ff + 16'd1;
      we        = 1'b0;
      load      = 1'b0;
      store     = 1'b0;
      halt_set  = 1'b0;
      val       = '0;
      status    = ST_OK;
      if (halted_ff) begin
         next_line = pc_ff;
         status    = ST_HALT;
      end else begin
         unique case (s1_action_ff) inside
            ACT_ADD: begin
               we  = 1'b1;
               val = op_a + op_b;
            end
            ACT_ADDI: begin
               we  = 1'b1;
               val = sum;
            end
            ACT_SUB: begin
               we  = 1'b1;
               val = op_a - op_b;
            end
            ACT_SUBI: begin
               we  = 1'b1;
               val = op_a - s1_imm_ff;
            end
            ACT_SLT: begin
               we  = 1'b1;
               val = {31'd0, $signed(op_a) < $signed(op_b)};
            end
            ACT_LI, ACT_LA: begin
               we  = 1'b1;
               val = s1_imm_ff;
            end
            ACT_LW: begin
               if (dm_ok) begin
                  we   = 1'b1;
                  load = 1'b1;
               end else begin
                  status = ST_ADDR;
               end
            end
            ACT_SW: begin
               if (dm_ok) begin
                  store = 1'b1;
               end else begin
                  status = ST_ADDR;
               end
            end
            ACT_BEQ: begin
               if (op_a == op_b) begin
                  next_line = s1_target_ff;
               end
            end
            ACT_BNE: begin
               if (op_a != op_b) begin
                  next_line = s1_target_ff;
               end
            end
            ACT_J: begin
               next_line = s1_target_ff;
            end
            ACT_SYSCALL: begin
               if (op_a == SYS_EXIT) begin
                  status    = ST_HALT;
                  halt_set  = 1'b1;
                  next_line = pc_ff;
               end else begin
                  status = ST_BAD_SYS;
               end
            end
            default: begin
               // label and the unused codes do nothing but advance the line
            end
         endcase
      end
   end

   assign we_fin = we && (s1_dest_ff != REG_ZERO);

   assign dm_rd_en = s1_adv && load && we_fin;
   assign dm_wr_en = s1_adv && store;

   rsxu_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .addr    (sum),
      .rd_en   (dm_rd_en),
      .wr_en   (dm_wr_en),
      .wr_data (op_b),
      .addr_ok (dm_ok),
      .busy    (dm_busy),
      .rd_data (dm_rdata)
   );

   assign rf_wr = '{en: s2_adv && s2_we_ff, addr: s2_reg_ff, data: s2_data};

   // control next state
   always_comb begin
      s1_v_in = s1_v_ff;
      if (accept) begin
         s1_v_in = 1'b1;
      end else if (s1_adv) begin
         s1_v_in = 1'b0;
      end
      s2_v_in = s2_v_ff;
      if (s1_adv) begin
         s2_v_in = 1'b1;
      end else if (s2_adv) begin
         s2_v_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      pc_in     = s1_adv ? next_line : pc_ff;
      halted_in = halted_ff || (s1_adv && halt_set);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
      end else begin
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_action;
         s1_dest_ff   <= req_dest_reg;
         s1_imm_ff    <= req_immediate;
         s1_target_ff <= req_target_line;
      end
      if (s1_adv) begin
         s2_we_ff     <= we_fin;
         // a load into register zero reads nothing and reports no value
         s2_load_ff   <= load && we_fin;
         s2_reg_ff    <= we_fin ? s1_dest_ff : REG_ZERO;
         s2_val_ff    <= we_fin ? val : '0;
         s2_next_ff   <= next_line;
         s2_status_ff <= status;
      end
      if (s2_adv) begin
         rsp_next_ff   <= s2_next_ff;
         rsp_we_ff     <= s2_we_ff;
         rsp_reg_ff    <= s2_reg_ff;
         rsp_val_ff    <= s2_data;
         rsp_status_ff <= s2_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_line    = rsp_next_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_write_reg    = rsp_reg_ff;
   assign rsp_write_value  = rsp_val_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

### hw/rtl/rsxu_checker.sv
// Port-level checks for the execute unit, bound to the top level.
`default_nettype none

module rsxu_checker
   import rsxu_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic        [3:0]  req_action,
   input wire logic        [4:0]  req_dest_reg,
   input wire logic        [4:0]  req_src_a_reg,
   input wire logic        [4:0]  req_src_b_reg,
   input wire logic signed [31:0] req_immediate,
   input wire logic        [15:0] req_target_line,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic        [15:0] rsp_next_line,
   input wire logic               rsp_write_enable,
   input wire logic        [4:0]  rsp_write_reg,
   input wire logic signed [31:0] rsp_write_value,
   input wire logic        [1:0]  rsp_status
);

   // a stalled item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_line)
         && $stable(rsp_status) && $stable(rsp_write_value))
      else $error("rsp item changed while stalled");

   // memory sweep blocks input right after reset
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("req taken during memory clear");

   // no write reported means zero write fields
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_write_reg == 5'd0
         && rsp_write_value == 32'sd0)
      else $error("write fields set without a write");

   // register zero is never written; errors and halts write nothing
   a_write_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |-> rsp_write_reg != REG_ZERO
         && rsp_status == ST_OK)
      else $error("illegal register write reported");

endmodule

bind risc_subset_execute_unit rsxu_checker u_rsxu_checker (.*);

`default_nettype wire

### tb/risc_subset_execute_unit_test.sv
// Self-checking testbench for the RISC subset execute unit.
module risc_subset_execute_unit_test;
   import rsxu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEM_WORDS    = 1024;
   localparam int WORD_BYTES   = 4;
   localparam int RANDOM_ITEMS = 1570;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES  = 150;
   // actions outside the defined set behave as a label
   localparam logic [3:0] ACT_SPARE = 4'd15;

   typedef struct packed {
      logic [3:0]  action;
      logic [4:0]  dest_reg;
      logic [4:0]  src_a_reg;
      logic [4:0]  src_b_reg;
      logic [31:0] immediate;
      logic [15:0] target_line;
   } instr_type;

   typedef struct packed {
      logic [15:0] next_line;
      logic        write_enable;
      logic [4:0]  write_reg;
      logic [31:0] write_value;
      logic [1:0]  status;
   } retire_type;

   typedef struct packed {
      logic [3:0]  action;
      logic [4:0]  dest_reg;
      logic [4:0]  src_a_reg;
      logic [4:0]  src_b_reg;
      logic [31:0] immediate;
      logic [15:0] target_line;
      logic        typed;
      logic [15:0] next_line;
      logic        write_enable;
      logic [4:0]  write_reg;
      logic [31:0] write_value;
      logic [1:0]  status;
   } vec_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [3:0]  req_action      = ACT_LABEL;
   logic [4:0]  req_dest_reg    = '0;
   logic [4:0]  req_src_a_reg   = '0;
   logic [4:0]  req_src_b_reg   = '0;
   logic signed [31:0] req_immediate = '0;
   logic [15:0] req_target_line = '0;

   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [15:0] rsp_next_line;
   logic        rsp_write_enable;
   logic [4:0]  rsp_write_reg;
   logic signed [31:0] rsp_write_value;
   logic [1:0]  rsp_status;

   // architectural state as the block should see it
   logic [31:0] arch_gpr [32]        = '{default: '0};
   logic [31:0] arch_mem [MEM_WORDS] = '{default: '0};
   logic [15:0] arch_line            = '0;
   bit          arch_halted          = 1'b0;

   retire_type retire_q [$];

   bit calm      = 1'b0;
   int errors    = 0;
   int sent      = 0;
   int checked   = 0;
   int mem_ops   = 0;
   int mem_fault = 0;
   int redirects = 0;
   int bad_sys   = 0;
   int hold_left = 0;
   bit held_once = 1'b0;

   logic [3:0] alu_ops [5] = '{ACT_ADD, ACT_ADDI, ACT_SUB, ACT_SUBI, ACT_SLT};

   vec_row_type directed_tab [0:24] = '{
      '{ACT_ADD,     1,  0, 0, 32'h0000_0000, 16'h0000, 1, 16'h0001, 1,  1, 32'h0000_0000, ST_OK},
      '{ACT_LI,      3,  0, 0, 32'h7FFF_FFFF, 16'h0000, 1, 16'h0002, 1,  3, 32'h7FFF_FFFF, ST_OK},
      '{ACT_LI,      4,  0, 0, 32'h8000_0000, 16'h0000, 1, 16'h0003, 1,  4, 32'h8000_0000, ST_OK},
      '{ACT_ADD,     5,  3, 3, 32'h0000_0000, 16'h0000, 1, 16'h0004, 1,  5, 32'hFFFF_FFFE, ST_OK},
      '{ACT_SUB,     6,  4, 3, 32'h0000_0000, 16'h0000, 1, 16'h0005, 1,  6, 32'h0000_0001, ST_OK},
      '{ACT_ADDI,    7,  3, 0, 32'h0000_0001, 16'h0000, 1, 16'h0006, 1,  7, 32'h8000_0000, ST_OK},
      '{ACT_SUBI,    8,  4, 0, 32'h0000_0001, 16'h0000, 1, 16'h0007, 1,  8, 32'h7FFF_FFFF, ST_OK},
      '{ACT_SLT,     9,  4, 3, 32'h0000_0000, 16'h0000, 1, 16'h0008, 1,  9, 32'h0000_0001, ST_OK},
      '{ACT_SLT,    10,  3, 4, 32'h0000_0000, 16'h0000, 1, 16'h0009, 1, 10, 32'h0000_0000, ST_OK},
      '{ACT_LA,      0,  0, 0, 32'h0000_1234, 16'h0000, 1, 16'h000A, 0,  0, 32'h0000_0000, ST_OK},
      '{ACT_LI,     11,  0, 0, 32'hFFFF_FFFF, 16'h0000, 1, 16'h000B, 1, 11, 32'hFFFF_FFFF, ST_OK},
      '{ACT_SW,      3,  0, 0, 32'd4092,      16'h0000, 1, 16'h000C, 0,  0, 32'h0000_0000, ST_OK},
      '{ACT_LW,     12,  0, 0, 32'd4095,      16'h0000, 1, 16'h000D, 1, 12, 32'h7FFF_FFFF, ST_OK},
      '{ACT_LW,     13,  0, 0, 32'd4096,      16'h0000, 1, 16'h000E, 0,  0, 32'h0000_0000, ST_ADDR},
      '{ACT_SW,      4,  0, 0, 32'hFFFF_FFFD, 16'h0000, 1, 16'h000F, 0,  0, 32'h0000_0000, ST_OK},
      // base -1 plus offset -2: rounds toward zero onto word 0
      '{ACT_LW,     14, 11, 0, 32'hFFFF_FFFE, 16'h0000, 0, 16'h0000, 0,  0, 32'h0000_0000, ST_OK},
      '{ACT_LW,     15,  0, 0, 32'hFFFF_FFFC, 16'h0000, 1, 16'h0011, 0,  0, 32'h0000_0000, ST_ADDR},
      '{ACT_SW,      4,  3, 0, 32'h0000_0001, 16'h0000, 1, 16'h0012, 0,  0, 32'h0000_0000, ST_ADDR},
      '{ACT_BEQ,     0,  3, 8, 32'h0000_0000, 16'hFFFF, 1, 16'hFFFF, 0,  0, 32'h0000_0000, ST_OK},
      '{ACT_BNE,     0,  0, 1, 32'h0000_0000, 16'h0064, 1, 16'h0000, 0,  0, 32'h0000_0000, ST_OK},
      '{ACT_BNE,     0,  3, 4, 32'h0000_0000, 16'h1234, 1, 16'h1234, 0,  0, 32'h0000_0000, ST_OK},
      '{ACT_J,       0,  0, 0, 32'h0000_0000, 16'h0000, 1, 16'h0000, 0,  0, 32'h0000_0000, ST_OK},
      '{ACT_SYSCALL, 0,  0, 0, 32'h0000_0000, 16'h0000, 1, 16'h0001, 0,  0, 32'h0000_0000,
        ST_BAD_SYS},
      '{ACT_LABEL,   0,  0, 0, 32'h0000_0000, 16'h0000, 1, 16'h0002, 0,  0, 32'h0000_0000, ST_OK},
      '{ACT_SPARE,   7,  1, 2, 32'hFFFF_FFFF, 16'hFFFF, 1, 16'h0003, 0,  0, 32'h0000_0000, ST_OK}
   };

   risc_subset_execute_unit #(.MEM_WORDS(MEM_WORDS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_dest_reg    (req_dest_reg),
      .req_src_a_reg   (req_src_a_reg),
      .req_src_b_reg   (req_src_b_reg),
      .req_immediate   (req_immediate),
      .req_target_line (req_target_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_next_line   (rsp_next_line),
      .rsp_write_enable(rsp_write_enable),
      .rsp_write_reg   (rsp_write_reg),
      .rsp_write_value (rsp_write_value),
      .rsp_status      (rsp_status)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit take_gap();
      return !calm && ($urandom_range(99) < 36);
   endfunction

   function automatic logic [31:0] read_gpr(logic [4:0] idx);
      return (idx == REG_ZERO) ? 32'd0 : arch_gpr[idx];
   endfunction

   // appends one expected result behind those still outstanding
   function automatic void queue_result(retire_type r);
      retire_q.insert(retire_q.size(), r);
   endfunction

   // executes one instruction against the architectural state
   function automatic retire_type execute_instr(instr_type it);
      retire_type  r;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] sum;
      logic [31:0] val;
      int          q;
      bit          wr;
      bit          in_range;
      r = '{next_line: arch_line + 16'd1, status: ST_OK, default: '0};
      if (arch_halted) begin
         r.next_line = arch_line;
         r.status = ST_HALT;
         return r;
      end
      a = read_gpr(it.src_a_reg);
      b = read_gpr(it.src_b_reg);
      sum = a + it.immediate;
      q = $signed(sum) / WORD_BYTES;
      in_range = (q >= 0) && (q < MEM_WORDS);
      wr = 1'b0;
      val = '0;
      case (it.action) inside
         ACT_ADD: begin wr = 1'b1; val = a + b; end
         ACT_ADDI: begin wr = 1'b1; val = a + it.immediate; end
         ACT_SUB: begin wr = 1'b1; val = a - b; end
         ACT_SUBI: begin wr = 1'b1; val = a - it.immediate; end
         ACT_SLT: begin wr = 1'b1; val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0; end
         ACT_LI, ACT_LA: begin wr = 1'b1; val = it.immediate; end
         ACT_LW, ACT_SW: begin
            mem_ops++;
            if (!in_range) begin
               r.status = ST_ADDR;
               mem_fault++;
            end else if (it.action == ACT_LW) begin
               wr = 1'b1;
               val = arch_mem[q];
            end else begin
               arch_mem[q] = read_gpr(it.dest_reg);
            end
         end
         ACT_BEQ: if (a == b) r.next_line = it.target_line;
         ACT_BNE: if (a != b) r.next_line = it.target_line;
         ACT_J: r.next_line = it.target_line;
         ACT_SYSCALL: begin
            if (read_gpr(REG_SYS) == SYS_EXIT) begin
               r.status = ST_HALT;
               r.next_line = arch_line;
               arch_halted = 1'b1;
            end else begin
               r.status = ST_BAD_SYS;
               bad_sys++;
            end
         end
         default: ;
      endcase
      if (r.next_line != arch_line + 16'd1 && !arch_halted) redirects++;
      if (wr && it.dest_reg != REG_ZERO) begin
         arch_gpr[it.dest_reg] = val;
         r.write_enable = 1'b1;
         r.write_reg = it.dest_reg;
         r.write_value = val;
      end
      arch_line = r.next_line;
      return r;
   endfunction

   function automatic logic [31:0] pick_imm();
      case ($urandom_range(3))
         0: return 32'($urandom_range(20)) - 32'd10;
         1: case ($urandom_range(4))
               0: return 32'h0000_0000;
               1: return 32'h0000_0001;
               2: return 32'h7FFF_FFFF;
               3: return 32'h8000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         default: return $urandom();
      endcase
   endfunction

   function automatic instr_type make_random_item();
      instr_type   it;
      int          addr;
      int unsigned roll;
      it.action      = ACT_LABEL;
      it.dest_reg    = 5'($urandom_range(31));
      it.src_a_reg   = 5'($urandom_range(31));
      it.src_b_reg   = 5'($urandom_range(31));
      it.immediate   = $urandom();
      it.target_line = 16'($urandom_range(16'hFFFF));
      roll = $urandom_range(99);
      if (roll < 30) begin
         it.action = alu_ops[$urandom_range(4)];
         it.immediate = pick_imm();
      end else if (roll < 42) begin
         it.action = $urandom_range(1) ? ACT_LI : ACT_LA;
         it.immediate = pick_imm();
         // keep register 2 near the exit code so the syscall guard gets exercised
         if ($urandom_range(9) == 0) begin
            it.dest_reg = REG_SYS;
            it.immediate = 32'($urandom_range(12, 8));
         end
      end else if (roll < 70) begin
         it.action = (roll < 56) ? ACT_LW : ACT_SW;
         case ($urandom_range(9))
            0, 1, 2, 3: addr = $urandom_range(7) * 4 + $urandom_range(3);
            4, 5: addr = (MEM_WORDS - 1 - $urandom_range(7)) * 4 + $urandom_range(3);
            6: addr = $urandom_range(MEM_WORDS * 4 - 1);
            7: addr = -int'($urandom_range(3, 1));
            8: addr = $urandom_range(1) ? MEM_WORDS * 4 + $urandom_range(7)
                                        : -4 - int'($urandom_range(7));
            default: addr = $urandom();
         endcase
         // offset chosen so that base + offset lands on the intended byte address
         it.immediate = 32'(addr) - read_gpr(it.src_a_reg);
      end else if (roll < 84) begin
         it.action = $urandom_range(1) ? ACT_BEQ : ACT_BNE;
         if ($urandom_range(1)) it.src_b_reg = it.src_a_reg;
      end else if (roll < 88) begin
         it.action = ACT_J;
      end else if (roll < 94) begin
         it.action = ACT_SYSCALL;
      end else begin
         it.action = 4'(ACT_LABEL + $urandom_range(2));
      end
      // an exit syscall would freeze the block, so it is saved for the end
      if (it.action == ACT_SYSCALL && read_gpr(REG_SYS) == SYS_EXIT) it.action = ACT_LABEL;
      return it;
   endfunction

   task automatic issue(input instr_type it, input bit typed, input retire_type want);
      retire_type got;
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= it.action;
      req_dest_reg    <= it.dest_reg;
      req_src_a_reg   <= it.src_a_reg;
      req_src_b_reg   <= it.src_b_reg;
      req_immediate   <= it.immediate;
      req_target_line <= it.target_line;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = execute_instr(it);
      queue_result(typed ? want : got);
      sent++;
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      retire_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (retire_q.size() == 0) begin
               $error("result item arrived with none outstanding");
               errors++;
            end else begin
               want = retire_q.pop_front();
               check_field("next_line", 32'(want.next_line), 32'(rsp_next_line));
               check_field("write_enable", 32'(want.write_enable), 32'(rsp_write_enable));
               check_field("write_reg", 32'(want.write_reg), 32'(rsp_write_reg));
               check_field("write_value", want.write_value, rsp_write_value);
               check_field("status", 32'(want.status), 32'(rsp_status));
               checked++;
            end
         end
      end
   end

   // receiver back-pressure: random gaps plus one long hold
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
         end else if (!held_once && checked >= 300) begin
            // long back-pressure so the pipeline fills and stalls its input
            hold_left = HOLD_CYCLES;
            held_once = 1'b1;
         end
         rsp_stall <= (hold_left > 0) || take_gap();
      end
   end

   initial begin : stimulus
      vec_row_type r;
      instr_type   it;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_tab[i]) begin
         r = directed_tab[i];
         it = '{r.action, r.dest_reg, r.src_a_reg, r.src_b_reg, r.immediate, r.target_line};
         issue(it, r.typed,
               '{r.next_line, r.write_enable, r.write_reg, r.write_value, r.status});
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 600 && n < 900);
         issue(make_random_item(), 1'b0, '0);
      end
      calm = 1'b0;
      // exit syscall last, then a few items that must all come back halted
      issue('{ACT_LI, REG_SYS, REG_ZERO, REG_ZERO, SYS_EXIT, 16'h0000}, 1'b0, '0);
      issue('{ACT_SYSCALL, REG_ZERO, REG_ZERO, REG_ZERO, 32'h0, 16'h0000}, 1'b0, '0);
      repeat (4) issue(make_random_item(), 1'b0, '0);
      req_valid <= 1'b0;
      while (retire_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d items sent (%0d directed), %0d results checked, halt tested at end",
               sent, $size(directed_tab), checked);
      $display("%0d loads/stores (%0d out of range), %0d line redirects, %0d bad syscalls",
               mem_ops, mem_fault, redirects, bad_sys);
      if (errors == 0)
         $display("risc_subset_execute_unit: match");
      else
         $display("risc_subset_execute_unit: mismatch");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("risc_subset_execute_unit: mismatch");
      $finish;
   end

endmodule

### sim.f
hw/rtl/rsxu_pkg.sv
hw/rtl/rsxu_ram.sv
hw/rtl/rsxu_regfile.sv
hw/rtl/rsxu_dmem.sv
hw/rtl/risc_subset_execute_unit.sv
hw/rtl/rsxu_checker.sv
tb/risc_subset_execute_unit_test.sv
